// ----- sv/mltc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mltc_pkg - shared types and tables for the micro language token classifier
// character classes, dfa states, token codes and keyword spelling
// ----------------------------------------------------------------------------
package mltc_pkg;

  localparam int unsigned DataW         = 8;
  localparam int unsigned OutDataW      = 8;
  localparam int unsigned TokW          = 4;
  localparam int unsigned CountW        = 6;
  localparam int unsigned CountMax      = 63;
  localparam int unsigned NumKw         = 4;
  localparam int unsigned KwIdxW        = 3;
  localparam int unsigned MaxLenDefault = 32;

  typedef enum logic [TokW-1:0] {
    TOK_INICIO   = 4'd0,
    TOK_FIN      = 4'd1,
    TOK_LEER     = 4'd2,
    TOK_ESCRIBIR = 4'd3,
    TOK_IDENT    = 4'd4,
    TOK_CONST    = 4'd5,
    TOK_LPAREN   = 4'd6,
    TOK_RPAREN   = 4'd7,
    TOK_SEMI     = 4'd8,
    TOK_COMMA    = 4'd9,
    TOK_ASSIGN   = 4'd10,
    TOK_PLUS     = 4'd11,
    TOK_MINUS    = 4'd12,
    TOK_ERROR    = 4'd13
  } token_e;

  typedef enum logic [3:0] {
    CC_DIGIT  = 4'd0,
    CC_LETTER = 4'd1,
    CC_LPAREN = 4'd2,
    CC_RPAREN = 4'd3,
    CC_SEMI   = 4'd4,
    CC_COMMA  = 4'd5,
    CC_COLON  = 4'd6,
    CC_EQUAL  = 4'd7,
    CC_PLUS   = 4'd8,
    CC_MINUS  = 4'd9,
    CC_SPACE  = 4'd10,
    CC_OTHER  = 4'd11
  } char_class_e;

  // one-hot dfa state
  typedef enum logic [11:0] {
    ST_START  = 12'b0000_0000_0001,
    ST_NUMBER = 12'b0000_0000_0010,
    ST_IDENT  = 12'b0000_0000_0100,
    ST_LPAREN = 12'b0000_0000_1000,
    ST_RPAREN = 12'b0000_0001_0000,
    ST_SEMI   = 12'b0000_0010_0000,
    ST_COMMA  = 12'b0000_0100_0000,
    ST_COLON  = 12'b0000_1000_0000,
    ST_PLUS   = 12'b0001_0000_0000,
    ST_MINUS  = 12'b0010_0000_0000,
    ST_ASSIGN = 12'b0100_0000_0000,
    ST_DEAD   = 12'b1000_0000_0000
  } dfa_state_e;

  // keyword spelling, zero padded to eight characters
  localparam logic [7:0] KwText [NumKw][8] = '{
    '{"I", "N", "I", "C", "I", "O", 8'h00, 8'h00},
    '{"F", "I", "N", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"L", "E", "E", "R", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"E", "S", "C", "R", "I", "B", "I", "R"}
  };

  localparam logic [CountW-1:0] KwLen [NumKw] = '{6'd6, 6'd3, 6'd4, 6'd8};

  // c-locale character classes
  function automatic char_class_e char_class(input logic [DataW-1:0] b);
    char_class_e c;
    case (b) inside
      ["0":"9"]:                c = CC_DIGIT;
      ["A":"Z"], ["a":"z"]:     c = CC_LETTER;
      "(":                      c = CC_LPAREN;
      ")":                      c = CC_RPAREN;
      ";":                      c = CC_SEMI;
      ",":                      c = CC_COMMA;
      ":":                      c = CC_COLON;
      "=":                      c = CC_EQUAL;
      "+":                      c = CC_PLUS;
      "-":                      c = CC_MINUS;
      " ", [8'd9:8'd13]:        c = CC_SPACE;
      default:                  c = CC_OTHER;
    endcase
    return c;
  endfunction

  function automatic dfa_state_e next_state(input dfa_state_e s, input char_class_e c);
    dfa_state_e n;
    n = ST_DEAD;
    case (s)
      ST_START: begin
        case (c)
          CC_DIGIT:  n = ST_NUMBER;
          CC_LETTER: n = ST_IDENT;
          CC_LPAREN: n = ST_LPAREN;
          CC_RPAREN: n = ST_RPAREN;
          CC_SEMI:   n = ST_SEMI;
          CC_COMMA:  n = ST_COMMA;
          CC_COLON:  n = ST_COLON;
          CC_PLUS:   n = ST_PLUS;
          CC_MINUS:  n = ST_MINUS;
          CC_SPACE:  n = ST_START;
          default:   n = ST_DEAD;
        endcase
      end
      ST_NUMBER: n = (c == CC_DIGIT) ? ST_NUMBER : ST_DEAD;
      ST_IDENT:  n = (c == CC_DIGIT || c == CC_LETTER) ? ST_IDENT : ST_DEAD;
      ST_COLON:  n = (c == CC_EQUAL) ? ST_ASSIGN : ST_DEAD;
      default:   n = ST_DEAD;
    endcase
    return n;
  endfunction

  // token for an end state; identifiers still go through the keyword check
  function automatic token_e end_token(input dfa_state_e s);
    token_e t;
    case (s)
      ST_NUMBER: t = TOK_CONST;
      ST_IDENT:  t = TOK_IDENT;
      ST_LPAREN: t = TOK_LPAREN;
      ST_RPAREN: t = TOK_RPAREN;
      ST_SEMI:   t = TOK_SEMI;
      ST_COMMA:  t = TOK_COMMA;
      ST_PLUS:   t = TOK_PLUS;
      ST_MINUS:  t = TOK_MINUS;
      ST_ASSIGN: t = TOK_ASSIGN;
      default:   t = TOK_ERROR;
    endcase
    return t;
  endfunction

  // character of keyword k at position idx matches b
  function automatic logic kw_char_match(input logic [1:0] k, input logic [KwIdxW-1:0] idx,
                                         input logic [DataW-1:0] b);
    return KwText[k][idx] == b;
  endfunction

endpackage

// ----- sv/micro_language_token_classifier_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// micro_language_token_classifier_core - table driven lexer for the micro language
// classifies one lexeme per run of bytes and gives its token class
// ----------------------------------------------------------------------------
// usage
//   slave side: one character per word in s_axis_tdata_i; a word with
//   s_axis_tlast_i high is the end marker, its data is ignored and it closes
//   the lexeme. ordinary characters give no result.
//   master side: one word per end marker, m_axis_tdata_o[3:0] is the token
//   class (0..3 keywords, 4 identifier, 5 constant, 6..12 punctuation and
//   operators, 13 error), upper bits zero.
// latency and throughput
//   one word per cycle. the dfa step, keyword compares and length count are
//   done in the cycle a word is taken, so the token is valid in the cycle
//   after the end marker is taken. when the receiver takes the token in that
//   cycle the next word is taken too, so lexemes follow with no gap.
// reset
//   scan state goes to the start state, count to zero, all keywords alive,
//   no token pending.
// stall
//   while a token waits and the receiver holds tready low, s_axis_tready_o
//   drops; otherwise words are taken every cycle.
// ----------------------------------------------------------------------------
module micro_language_token_classifier_core #(
  parameter int unsigned MAX_LEN = mltc_pkg::MaxLenDefault  // 1..62
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // slave side
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [mltc_pkg::DataW-1:0]      s_axis_tdata_i,   // [7:0] char_byte
  input  logic                            s_axis_tlast_i,   // end_of_text
  // master side
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [mltc_pkg::OutDataW-1:0]   m_axis_tdata_o    // [3:0] token_class, rest zero
);

  // scan state
  mltc_pkg::dfa_state_e                   state_q, state_d;
  logic [mltc_pkg::CountW-1:0]            count_q, count_d;
  logic [mltc_pkg::NumKw-1:0]             kw_alive_q, kw_alive_d;

  // result register
  logic                                   out_valid_q, out_valid_d;
  mltc_pkg::token_e                       out_tok_q, tok_d;

  logic s_fire;
  logic m_fire;
  mltc_pkg::char_class_e cls;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;
  assign m_fire          = out_valid_q && m_axis_tready_i;
  assign cls             = mltc_pkg::char_class(s_axis_tdata_i);

  // scan update
  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    kw_alive_d = kw_alive_q;
    if (s_fire) begin
      if (s_axis_tlast_i) begin
        // end of lexeme, back to the start
        state_d    = mltc_pkg::ST_START;
        count_d    = '0;
        kw_alive_d = '1;
      end else if (state_q != mltc_pkg::ST_DEAD) begin
        for (int k = 0; k < mltc_pkg::NumKw; k++) begin
          if (count_q >= mltc_pkg::KwLen[k] ||
              !mltc_pkg::kw_char_match(2'(k), count_q[mltc_pkg::KwIdxW-1:0],
                                       s_axis_tdata_i)) begin
            kw_alive_d[k] = 1'b0;
          end
        end
        state_d = mltc_pkg::next_state(state_q, cls);
        // count saturates so long lexemes stay flagged
        if (count_q != mltc_pkg::CountW'(mltc_pkg::CountMax)) begin
          count_d = count_q + mltc_pkg::CountW'(1);
        end
      end
    end
  end

  // token for the lexeme seen so far
  always_comb begin
    tok_d = mltc_pkg::TOK_ERROR;
    if (count_q <= mltc_pkg::CountW'(MAX_LEN)) begin
      tok_d = mltc_pkg::end_token(state_q);
      if (state_q == mltc_pkg::ST_IDENT) begin
        // lowest keyword index wins
        for (int k = mltc_pkg::NumKw - 1; k >= 0; k--) begin
          if (kw_alive_q[k] && count_q == mltc_pkg::KwLen[k]) begin
            tok_d = mltc_pkg::token_e'(mltc_pkg::TokW'(k));
          end
        end
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (s_fire && s_axis_tlast_i) begin
      out_valid_d = 1'b1;
    end else if (m_fire) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mltc_pkg::ST_START;
      count_q     <= '0;
      kw_alive_q  <= '1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      kw_alive_q  <= kw_alive_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire && s_axis_tlast_i) begin
      out_tok_q <= tok_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(mltc_pkg::OutDataW - mltc_pkg::TokW){1'b0}}, out_tok_q};

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------

  // an end marker always leaves a token pending
  a_eot_gives_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && s_axis_tlast_i |=> out_valid_q)
    else $error("end marker taken without a token");

  // an end marker returns the scanner to its reset state
  a_eot_clears_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && s_axis_tlast_i |=>
      state_q == mltc_pkg::ST_START && count_q == '0 && kw_alive_q == '1)
    else $error("scan state not cleared after end marker");

  // leaving the start state means at least one character was counted
  a_state_implies_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != mltc_pkg::ST_START |-> count_q != '0)
    else $error("scan state advanced without a character count");

  // the dead state freezes count and keyword mask on ordinary characters
  a_dead_freezes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && !s_axis_tlast_i && state_q == mltc_pkg::ST_DEAD |=>
      $stable(count_q) && $stable(kw_alive_q) && state_q == mltc_pkg::ST_DEAD)
    else $error("dead state changed scan state");

  // a token in the result register is never beyond the error code
  a_token_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_tok_q <= mltc_pkg::TOK_ERROR)
    else $error("token class out of range");

endmodule
